/* design/damage_rect_accumulator_assert.svh */
// Assertion macros for the damage rectangle accumulator
`ifndef DAMAGE_RECT_ACCUMULATOR_ASSERT_SVH
`define DAMAGE_RECT_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication
`define DRA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define DRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dra_pkg.sv */
`timescale 1ns / 1ps

package dra_pkg;

   localparam int COORD_BITS_DEF = 14;
   localparam int SCREEN_W_RESET = 1280;
   localparam int SCREEN_H_RESET = 720;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      FUNC_MARK_RECT = 2'd0,
      FUNC_MARK_FULL = 2'd1,
      FUNC_MERGE     = 2'd2,
      FUNC_SNAPSHOT  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLIP,
      ST_APPLY,
      ST_AREA,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic load;
      logic clip;
      logic apply;
      logic area;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

/* design/dra_csr.sv */
`timescale 1ns / 1ps

module dra_csr #(
   parameter int COORD_BITS = dra_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dra_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [dra_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [dra_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output logic [COORD_BITS-1:0]              screen_w,
   output logic [COORD_BITS-1:0]              screen_h
);
   import dra_pkg::*;

   logic [COORD_BITS-1:0] screen_w_ff, screen_w_in;
   logic [COORD_BITS-1:0] screen_h_ff, screen_h_in;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      screen_w_in = screen_w_ff;
      screen_h_in = screen_h_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_SCREEN_WIDTH:  screen_w_in = csr_pwdata[COORD_BITS-1:0];
            REG_SCREEN_HEIGHT: screen_h_in = csr_pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_BITS'(screen_w_ff);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_BITS'(screen_h_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff <= COORD_BITS'(SCREEN_W_RESET);
         screen_h_ff <= COORD_BITS'(SCREEN_H_RESET);
      end else begin
         screen_w_ff <= screen_w_in;
         screen_h_ff <= screen_h_in;
      end
   end

   assign screen_w = screen_w_ff;
   assign screen_h = screen_h_ff;

endmodule

/* design/dra_ctrl.sv */
`timescale 1ns / 1ps

module dra_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  dra_pkg::dp_status_type status,
   output dra_pkg::dp_cmd_type    cmd
);
   import dra_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_CLIP;
         ST_CLIP:  state_in = ST_APPLY;
         ST_APPLY: state_in = ST_AREA;
         ST_AREA:  state_in = ST_CHECK;
         ST_CHECK: if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CLIP:  cmd.clip  = 1'b1;
         ST_APPLY: cmd.apply = 1'b1;
         ST_AREA:  cmd.area  = 1'b1;
         ST_CHECK: cmd.emit  = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/dra_dp.sv */
`timescale 1ns / 1ps

module dra_dp #(
   parameter int COORD_BITS = dra_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dra_pkg::dp_cmd_type           cmd,
   output dra_pkg::dp_status_type        status,
   input  dra_pkg::func_type             in_func,
   input  logic                          in_defer,
   input  logic signed [COORD_BITS-1:0]  in_rect_x,
   input  logic signed [COORD_BITS-1:0]  in_rect_y,
   input  logic signed [COORD_BITS-1:0]  in_rect_w,
   input  logic signed [COORD_BITS-1:0]  in_rect_h,
   input  logic [COORD_BITS-1:0]         screen_w,
   input  logic [COORD_BITS-1:0]         screen_h,
   input  logic                          rsp_tready,
   output logic                          out_valid,
   output logic                          out_has,
   output logic                          out_full,
   output logic [COORD_BITS-2:0]         out_x,
   output logic [COORD_BITS-2:0]         out_y,
   output logic [COORD_BITS-1:0]         out_w,
   output logic [COORD_BITS-1:0]         out_h,
   output logic                          out_live_dirty,
   output logic                          out_pend_dirty
);
   import dra_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int EW = COORD_BITS + 2;
   localparam int PW = 2 * COORD_BITS;

   function automatic logic [2*CB-1:0] clip_axis(input logic signed [EW-1:0] pos,
                                                 input logic signed [EW-1:0] len,
                                                 input logic signed [EW-1:0] lim);
      logic signed [EW-1:0] far, hi, lo, sz;
      far = pos + len;
      hi  = (far < lim) ? far : lim;
      lo  = pos[EW-1] ? '0 : pos;
      sz  = (hi > lo) ? hi - lo : '0;
      return {lo[CB-1:0], sz[CB-1:0]};
   endfunction

   function automatic logic [2*CB-1:0] union_axis(input logic [CB-1:0] pa,
                                                  input logic [CB-1:0] la,
                                                  input logic [CB-1:0] pb,
                                                  input logic [CB-1:0] lb);
      logic [CB:0]   fa, fb, hi, sz;
      logic [CB-1:0] lo;
      fa = {1'b0, pa} + {1'b0, la};
      fb = {1'b0, pb} + {1'b0, lb};
      hi = (fa > fb) ? fa : fb;
      lo = (pa < pb) ? pa : pb;
      sz = hi - {1'b0, lo};
      return {lo, sz[CB-1:0]};
   endfunction

   func_type               func_ff;
   logic                   defer_ff;
   logic signed [CB-1:0]   rx_ff, ry_ff, rw_ff, rh_ff;

   logic [CB-1:0]          cx_ff, cy_ff, cw_ff, ch_ff;
   logic [CB-1:0]          cx_in, cy_in, cw_in, ch_in;

   logic                   live_dirty_ff, live_dirty_in, live_full_ff, live_full_in;
   logic [CB-1:0]          lx_ff, ly_ff, lw_ff, lh_ff, lx_in, ly_in, lw_in, lh_in;
   logic                   pend_dirty_ff, pend_dirty_in, pend_full_ff, pend_full_in;
   logic [CB-1:0]          px_ff, py_ff, pw_ff, ph_ff, px_in, py_in, pw_in, ph_in;

   logic                   res_has_ff, res_has_in, res_full_ff, res_full_in;
   logic [CB-1:0]          res_x_ff, res_y_ff, res_w_ff, res_h_ff;
   logic [CB-1:0]          res_x_in, res_y_in, res_w_in, res_h_in;
   logic                   area_chk_ff, area_chk_in;

   logic [PW-1:0]          ua_ff, sa_ff, ua_in, sa_in;
   logic [PW+2:0]          ua5, sa3;
   logic                   escalate;

   logic signed [EW-1:0]   sx, sy, sw, sh;
   logic [2*CB-1:0]        clip_xr, clip_yr, uni_xr, uni_yr;
   logic [CB-1:0]          bx, by, bw, bh;
   logic                   clip_empty, live_empty, pend_empty, live_mark, to_pend;

   logic                   out_valid_ff;
   logic                   out_has_ff, out_full_ff, out_ld_ff, out_pd_ff;
   logic [CB-2:0]          out_x_ff, out_y_ff;
   logic [CB-1:0]          out_w_ff, out_h_ff;

   // Clip source
   always_comb begin
      case (func_ff)
         FUNC_MERGE: begin
            sx = {2'b00, px_ff};
            sy = {2'b00, py_ff};
            sw = {2'b00, pw_ff};
            sh = {2'b00, ph_ff};
         end
         FUNC_SNAPSHOT: begin
            sx = {2'b00, lx_ff};
            sy = {2'b00, ly_ff};
            sw = {2'b00, lw_ff};
            sh = {2'b00, lh_ff};
         end
         default: begin
            sx = {{2{rx_ff[CB-1]}}, rx_ff};
            sy = {{2{ry_ff[CB-1]}}, ry_ff};
            sw = {{2{rw_ff[CB-1]}}, rw_ff};
            sh = {{2{rh_ff[CB-1]}}, rh_ff};
         end
      endcase
   end

   assign clip_xr = clip_axis(sx, sw, {2'b00, screen_w});
   assign clip_yr = clip_axis(sy, sh, {2'b00, screen_h});
   assign cx_in   = clip_xr[2*CB-1:CB];
   assign cw_in   = clip_xr[CB-1:0];
   assign cy_in   = clip_yr[2*CB-1:CB];
   assign ch_in   = clip_yr[CB-1:0];

   assign clip_empty = (cw_ff == '0) || (ch_ff == '0);
   assign live_empty = (lw_ff == '0) || (lh_ff == '0);
   assign pend_empty = (pw_ff == '0) || (ph_ff == '0);
   assign to_pend    = (func_ff == FUNC_MARK_RECT) && defer_ff;

   assign bx = to_pend ? px_ff : lx_ff;
   assign by = to_pend ? py_ff : ly_ff;
   assign bw = to_pend ? pw_ff : lw_ff;
   assign bh = to_pend ? ph_ff : lh_ff;

   assign uni_xr = union_axis(bx, bw, cx_ff, cw_ff);
   assign uni_yr = union_axis(by, bh, cy_ff, ch_ff);

   assign ua_in    = lw_ff * lh_ff;
   assign sa_in    = screen_w * screen_h;
   assign ua5      = {1'b0, ua_ff, 2'b00} + {3'b000, ua_ff};
   assign sa3      = {2'b00, sa_ff, 1'b0} + {3'b000, sa_ff};
   assign escalate = area_chk_ff && (sa_ff != '0) && (ua5 >= sa3);

   always_comb begin
      live_dirty_in = live_dirty_ff;
      live_full_in  = live_full_ff;
      lx_in = lx_ff;
      ly_in = ly_ff;
      lw_in = lw_ff;
      lh_in = lh_ff;
      pend_dirty_in = pend_dirty_ff;
      pend_full_in  = pend_full_ff;
      px_in = px_ff;
      py_in = py_ff;
      pw_in = pw_ff;
      ph_in = ph_ff;
      res_has_in  = res_has_ff;
      res_full_in = res_full_ff;
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;
      res_w_in = res_w_ff;
      res_h_in = res_h_ff;
      area_chk_in = area_chk_ff;
      live_mark   = 1'b0;

      if (cmd.apply) begin
         area_chk_in = 1'b0;
         res_has_in  = 1'b0;
         res_full_in = 1'b0;
         res_x_in = '0;
         res_y_in = '0;
         res_w_in = '0;
         res_h_in = '0;
         case (func_ff)
            FUNC_MARK_RECT: begin
               if (!defer_ff) begin
                  live_mark = 1'b1;
               end else if (pend_full_ff) begin
                  pend_dirty_in = 1'b1;
               end else if (!clip_empty) begin
                  pend_dirty_in = 1'b1;
                  if (!pend_dirty_ff || pend_empty) begin
                     px_in = cx_ff;
                     py_in = cy_ff;
                     pw_in = cw_ff;
                     ph_in = ch_ff;
                  end else begin
                     px_in = uni_xr[2*CB-1:CB];
                     pw_in = uni_xr[CB-1:0];
                     py_in = uni_yr[2*CB-1:CB];
                     ph_in = uni_yr[CB-1:0];
                  end
               end
            end
            FUNC_MARK_FULL: begin
               if (defer_ff) begin
                  pend_dirty_in = 1'b1;
                  pend_full_in  = 1'b1;
               end else begin
                  live_dirty_in = 1'b1;
                  live_full_in  = 1'b1;
               end
            end
            FUNC_MERGE: begin
               if (pend_dirty_ff) begin
                  if (pend_full_ff) begin
                     live_dirty_in = 1'b1;
                     live_full_in  = 1'b1;
                  end else begin
                     live_mark = 1'b1;
                  end
                  pend_dirty_in = 1'b0;
                  pend_full_in  = 1'b0;
                  px_in = '0;
                  py_in = '0;
                  pw_in = '0;
                  ph_in = '0;
               end
            end
            FUNC_SNAPSHOT: begin
               if (live_dirty_ff) begin
                  if (live_full_ff || live_empty) begin
                     res_has_in  = 1'b1;
                     res_full_in = 1'b1;
                     res_w_in    = screen_w;
                     res_h_in    = screen_h;
                  end else if (!clip_empty) begin
                     res_has_in = 1'b1;
                     res_x_in   = cx_ff;
                     res_y_in   = cy_ff;
                     res_w_in   = cw_ff;
                     res_h_in   = ch_ff;
                  end
               end
               live_dirty_in = 1'b0;
               live_full_in  = 1'b0;
               lx_in = '0;
               ly_in = '0;
               lw_in = '0;
               lh_in = '0;
            end
            default: ;
         endcase

         if (live_mark) begin
            if (live_full_ff) begin
               live_dirty_in = 1'b1;
            end else if (!clip_empty) begin
               live_dirty_in = 1'b1;
               area_chk_in   = 1'b1;
               if (!live_dirty_ff || live_empty) begin
                  lx_in = cx_ff;
                  ly_in = cy_ff;
                  lw_in = cw_ff;
                  lh_in = ch_ff;
               end else begin
                  lx_in = uni_xr[2*CB-1:CB];
                  lw_in = uni_xr[CB-1:0];
                  ly_in = uni_yr[2*CB-1:CB];
                  lh_in = uni_yr[CB-1:0];
               end
            end
         end
      end

      if (cmd.emit && escalate) begin
         live_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= in_func;
         defer_ff <= in_defer;
         rx_ff    <= in_rect_x;
         ry_ff    <= in_rect_y;
         rw_ff    <= in_rect_w;
         rh_ff    <= in_rect_h;
      end
      if (cmd.clip) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cw_ff <= cw_in;
         ch_ff <= ch_in;
      end
      if (cmd.area) begin
         ua_ff <= ua_in;
         sa_ff <= sa_in;
      end
      res_has_ff  <= res_has_in;
      res_full_ff <= res_full_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_w_ff    <= res_w_in;
      res_h_ff    <= res_h_in;
      if (cmd.emit) begin
         out_has_ff  <= res_has_ff;
         out_full_ff <= res_full_ff;
         out_x_ff    <= res_x_ff[CB-2:0];
         out_y_ff    <= res_y_ff[CB-2:0];
         out_w_ff    <= res_w_ff;
         out_h_ff    <= res_h_ff;
         out_ld_ff   <= live_dirty_ff;
         out_pd_ff   <= pend_dirty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_dirty_ff <= 1'b1;
         live_full_ff  <= 1'b1;
         lx_ff <= '0;
         ly_ff <= '0;
         lw_ff <= '0;
         lh_ff <= '0;
         pend_dirty_ff <= 1'b0;
         pend_full_ff  <= 1'b0;
         px_ff <= '0;
         py_ff <= '0;
         pw_ff <= '0;
         ph_ff <= '0;
         area_chk_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         live_dirty_ff <= live_dirty_in;
         live_full_ff  <= live_full_in;
         lx_ff <= lx_in;
         ly_ff <= ly_in;
         lw_ff <= lw_in;
         lh_ff <= lh_in;
         pend_dirty_ff <= pend_dirty_in;
         pend_full_ff  <= pend_full_in;
         px_ff <= px_in;
         py_ff <= py_in;
         pw_ff <= pw_in;
         ph_ff <= ph_in;
         area_chk_ff <= area_chk_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;

   assign out_valid      = out_valid_ff;
   assign out_has        = out_has_ff;
   assign out_full       = out_full_ff;
   assign out_x          = out_x_ff;
   assign out_y          = out_y_ff;
   assign out_w          = out_w_ff;
   assign out_h          = out_h_ff;
   assign out_live_dirty = out_ld_ff;
   assign out_pend_dirty = out_pd_ff;

endmodule

/* design/damage_rect_accumulator.sv */
// Screen damage tracker: keeps live and pending damage as one bounding box each.
// Request channel (req_): tuser carries the operation and the defer flag, tdata the
// rectangle; operations are mark rectangle, mark full screen, merge pending, snapshot.
// Every request transaction produces exactly one response transaction (rsp_) that
// carries the snapshot rectangle and flags plus the live and pending dirty flags.
// Screen width and height are set through the csr_ port at byte addresses 0 and 4;
// write them only while no request is in flight.
// The response is loaded into its output register at the check/emit step.
// Requests are taken one at a time: the controller runs the sequence of
// clip, apply, area multiply and check/emit steps over one shared datapath.
// The response sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, the next request stops at its emit step until
// the held response is taken; nothing is dropped.
// Reset: synchronous, active high; the live set starts dirty and full (first
// snapshot reports the whole screen), the pending set starts clear and the
// screen is 1280 x 720.
`timescale 1ns / 1ps
`include "damage_rect_accumulator_assert.svh"

module damage_rect_accumulator #(
   parameter int  COORD_BITS = dra_pkg::COORD_BITS_DEF,
   localparam int TDATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rect_x, rect_y, rect_w, rect_h
   input  logic [TDATA_BITS-1:0]             req_tdata,
   // func, defer
   input  logic [2:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // damage_x, damage_y, damage_w, damage_h, live_dirty_now, pending_dirty_now
   output logic [TDATA_BITS-1:0]             rsp_tdata,
   // frame_has_damage, damage_full
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dra_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dra_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dra_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import dra_pkg::*;

   localparam int CB       = COORD_BITS;
   localparam int DMG_BITS = 4 * COORD_BITS - 2;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   logic [CB-1:0] screen_w, screen_h;
   logic          out_has, out_full, out_ld, out_pd;
   logic [CB-2:0] out_x, out_y;
   logic [CB-1:0] out_w, out_h;

   dra_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .screen_w    (screen_w),
      .screen_h    (screen_h)
   );

   dra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   dra_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .in_func        (func_type'(req_tuser[1:0])),
      .in_defer       (req_tuser[2]),
      .in_rect_x      ($signed(req_tdata[CB-1:0])),
      .in_rect_y      ($signed(req_tdata[2*CB-1:CB])),
      .in_rect_w      ($signed(req_tdata[3*CB-1:2*CB])),
      .in_rect_h      ($signed(req_tdata[4*CB-1:3*CB])),
      .screen_w       (screen_w),
      .screen_h       (screen_h),
      .rsp_tready     (rsp_tready),
      .out_valid      (rsp_tvalid),
      .out_has        (out_has),
      .out_full       (out_full),
      .out_x          (out_x),
      .out_y          (out_y),
      .out_w          (out_w),
      .out_h          (out_h),
      .out_live_dirty (out_ld),
      .out_pend_dirty (out_pd)
   );

   assign rsp_tdata = TDATA_BITS'({out_pd, out_ld, out_h, out_w, out_y, out_x});
   assign rsp_tuser = {out_full, out_has};

   `DRA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while one is in flight")
   `DRA_ASSERT_NEXT(a_emit_valid, clock, reset, dp_cmd.emit, rsp_tvalid, "emitted response not presented")
   `DRA_ASSERT_IMPLY(a_no_damage_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[DMG_BITS-1:0] == '0, "damage rectangle without damage")
   `DRA_ASSERT_IMPLY(a_full_has, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0], "full damage reported as no damage")

endmodule
